### rtl/pf_pkg.sv
package pf_pkg;

  // default operand width
  localparam int VALUE_WIDTH_DEF = 31;

  // first trial divisor
  localparam int FIRST_DIVISOR = 2;

  // result status codes
  localparam logic [1:0] ST_COMPOSITE = 2'd0;
  localparam logic [1:0] ST_PRIME     = 2'd1;
  localparam logic [1:0] ST_BELOW_TWO = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DECIDE,
    S_EMIT_FACTOR,
    S_EMIT_LAST,
    S_EMIT_SMALL
  } state_t;

  // which result beat the datapath loads into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FACTOR,
    EMIT_LAST,
    EMIT_SMALL
  } emit_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  div_step;
    logic  take_factor;
    logic  inc_div;
    emit_t emit;
  } pf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic below_two;
    logic div_last;
    logic d_gt_q;
    logic rem_zero;
    logic out_free;
  } pf_stat_t;

endpackage

### rtl/pf_ctrl.sv
module pf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pf_pkg::pf_stat_t stat,
  output pf_pkg::pf_cmd_t  cmd
);

  pf_pkg::state_t state;
  pf_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      pf_pkg::S_IDLE: begin
        if (in_valid) state_next = pf_pkg::S_CHECK;
      end
      pf_pkg::S_CHECK: begin
        if (stat.below_two) state_next = pf_pkg::S_EMIT_SMALL;
        else                state_next = pf_pkg::S_DIV;
      end
      pf_pkg::S_DIV: begin
        if (stat.div_last) state_next = pf_pkg::S_DECIDE;
      end
      pf_pkg::S_DECIDE: begin
        if (stat.d_gt_q)        state_next = pf_pkg::S_EMIT_LAST;
        else if (stat.rem_zero) state_next = pf_pkg::S_EMIT_FACTOR;
        else                    state_next = pf_pkg::S_CHECK;
      end
      pf_pkg::S_EMIT_FACTOR: begin
        if (stat.out_free) state_next = pf_pkg::S_CHECK;
      end
      pf_pkg::S_EMIT_LAST, pf_pkg::S_EMIT_SMALL: begin
        if (stat.out_free) state_next = pf_pkg::S_IDLE;
      end
      default: state_next = pf_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.emit     = pf_pkg::EMIT_NONE;
    in_stall     = 1'b1;
    unique case (state)
      pf_pkg::S_IDLE: begin
        // no beat taken while in reset
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      pf_pkg::S_CHECK: begin
        cmd.div_start = !stat.below_two;
      end
      pf_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      pf_pkg::S_DECIDE: begin
        cmd.inc_div = !stat.d_gt_q && !stat.rem_zero;
      end
      pf_pkg::S_EMIT_FACTOR: begin
        if (stat.out_free) begin
          cmd.emit        = pf_pkg::EMIT_FACTOR;
          cmd.take_factor = 1'b1;
        end
      end
      pf_pkg::S_EMIT_LAST: begin
        if (stat.out_free) cmd.emit = pf_pkg::EMIT_LAST;
      end
      pf_pkg::S_EMIT_SMALL: begin
        if (stat.out_free) cmd.emit = pf_pkg::EMIT_SMALL;
      end
      default: ;
    endcase
  end

endmodule

### rtl/pf_datapath.sv
module pf_datapath #(
  parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  pf_pkg::pf_cmd_t        cmd,
  output pf_pkg::pf_stat_t       stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] factor,
  output logic [1:0]             status,
  output logic                   last
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] div;
  logic                   found;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] part;
  logic [CW-1:0]          cnt;

  logic [VALUE_WIDTH:0]   part_sh;
  logic [VALUE_WIDTH:0]   part_diff;
  logic                   qbit;

  // one restoring division step: shift in next dividend bit, try subtract
  assign part_sh   = {part, quo[VALUE_WIDTH-1]};
  assign part_diff = part_sh - {1'b0, div};
  assign qbit      = part_sh >= {1'b0, div};

  // status to controller
  assign stat.below_two = (rem[VALUE_WIDTH-1:1] == '0);
  assign stat.div_last  = (cnt == CW'(VALUE_WIDTH - 1));
  assign stat.d_gt_q    = (div > quo);
  assign stat.rem_zero  = (part == '0);
  assign stat.out_free  = !out_valid || !out_stall;

  // working value, trial divisor and found flag
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.take_factor) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= value;
      div <= VALUE_WIDTH'(pf_pkg::FIRST_DIVISOR);
    end else begin
      if (cmd.take_factor) rem <= quo;
      if (cmd.inc_div)     div <= div + VALUE_WIDTH'(1);
    end
  end

  // iterative divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo  <= rem;
      part <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[VALUE_WIDTH-2:0], qbit};
      part <= qbit ? part_diff[VALUE_WIDTH-1:0] : part_sh[VALUE_WIDTH-1:0];
      cnt  <= cnt + CW'(1);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != pf_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      pf_pkg::EMIT_FACTOR: begin
        factor <= div;
        status <= pf_pkg::ST_COMPOSITE;
        last   <= 1'b0;
      end
      pf_pkg::EMIT_LAST: begin
        factor <= rem;
        status <= found ? pf_pkg::ST_COMPOSITE : pf_pkg::ST_PRIME;
        last   <= 1'b1;
      end
      pf_pkg::EMIT_SMALL: begin
        factor <= '0;
        status <= pf_pkg::ST_BELOW_TWO;
        last   <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/prime_factorizer.sv
// prime factorizer by trial division
//
// input channel: in_valid / in_stall carry one value per beat. in_stall is
// low only while the block is idle, so one value is factored at a time.
// output channel: out_valid / out_stall carry factor, status and last. the
// prime factors come in ascending order with repeats, last marks the final
// beat. a prime value gives one beat with the value and prime status; zero
// and one give one beat with factor 0 and below-two status.
// trials: each trial is a check, a division with one step per cycle in the
// shared restoring divider, and a decide; a found factor adds an emit
// state. an item takes one trial per trial divisor, up to sqrt(value) of
// them; values below two go from check straight to the emit state.
// a stalled output beat holds; the block waits in its emit state until the
// beat is taken, and the output register frees as the beat is taken.
// reset (synchronous, rst high) returns to idle and drops out_valid.
module prime_factorizer #(
  parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] factor,
  output logic [1:0]             status,
  output logic                   last
);

  pf_pkg::pf_cmd_t  cmd;
  pf_pkg::pf_stat_t stat;

  // controller
  pf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  pf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .factor    (factor),
    .status    (status),
    .last      (last)
  );

endmodule

### rtl/pf_checker.sv
module pf_checker #(
  parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [VALUE_WIDTH-1:0] factor,
  input logic [1:0]             status,
  input logic                   last
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(factor) && $stable(status)
      && $stable(last))
    else $error("stalled output beat changed");

  // an accepted value keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous value in work");

  // below-two result carries zero and ends the item
  a_below_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == pf_pkg::ST_BELOW_TWO |-> factor == '0 && last)
    else $error("below-two result malformed");

  // prime result ends the item; no unused status code
  a_prime_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pf_pkg::ST_COMPOSITE || status == pf_pkg::ST_BELOW_TWO
      || (status == pf_pkg::ST_PRIME && last)))
    else $error("bad status or prime result not last");

endmodule

bind prime_factorizer pf_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_pf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .factor    (factor),
  .status    (status),
  .last      (last)
);
